@@ design/brs_pkg.sv @@
// ----------------------------------------------------------------------------
// brs_pkg
// Shared widths, codes and types for the bilinear RGBA resampler.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int POS_W      = 12;  // pos_x / pos_y
  localparam int CH_W       = 8;   // one color channel
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int SRC_DIM_W  = 9;   // src_width / src_height registers
  localparam int DST_DIM_W  = 13;  // dst_width / dst_height registers
  localparam int STEP_W     = 25;  // step_x / step_y registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // stream word layouts
  localparam int IN_TDATA_W  = 56;  // pos_x, pos_y, red, green, blue, alpha
  localparam int IN_TUSER_W  = 1;   // kind
  localparam int OUT_TDATA_W = 32;  // red, green, blue, alpha
  localparam int OUT_TUSER_W = 1;   // range_error

  // word kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd5;

  // neighbor read order
  localparam logic [1:0] PH_TL = 2'd0;
  localparam logic [1:0] PH_TR = 2'd1;
  localparam logic [1:0] PH_BL = 2'd2;
  localparam logic [1:0] PH_BR = 2'd3;

  typedef logic [CH_W-1:0] chan_t;

endpackage

@@ design/bilinear_rgba_resampler.sv @@
// ----------------------------------------------------------------------------
// bilinear_rgba_resampler
// RGBA8 source image in a single-port pixel memory; query words return one
// bilinearly blended output pixel, load words write one source pixel.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata (low bit up)                        | tuser
//  s_axis    | in        | pos_x, pos_y, red, green, blue, alpha     | kind
//  m_axis    | out       | red, green, blue, alpha                   | range_error
//  cfg       | in        | write enable, register index, write data  | -
//
//  A query holds the memory port for its four neighbor reads, while the next
//  word can wait in stage 1; a load needs only a single memory write.
//  An in-range query passes stage 1, stage 2 reads, memory/tag, blend and output
//  registers; an out-of-range query skips the reads.
//  Synchronous active-high reset clears control, sets the config registers to
//  1x1 sizes, unit steps; pixel memory is not cleared, holds garbage until written.
//  A stalled output freezes the read and blend pipeline; loads still write.
// ----------------------------------------------------------------------------
module bilinear_rgba_resampler
  import brs_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int FRAC_BITS      = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, red, green, blue, alpha
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // red, green, blue, alpha
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // range_error
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW    = $clog2(MAX_SRC_WIDTH);
  localparam int RW    = $clog2(MAX_SRC_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = POS_W + STEP_W;         // scaled position
  localparam int XW    = PW - FRAC_BITS;         // integer part
  localparam int WW    = FRAC_BITS + 1;          // weight incl. 1.0
  localparam int HW    = CH_W + FRAC_BITS;       // one-axis blend
  localparam int ACW   = CH_W + 2 * FRAC_BITS;   // two-axis blend
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
  localparam logic [DST_DIM_W-1:0] MAXW = DST_DIM_W'(MAX_SRC_WIDTH);
  localparam logic [DST_DIM_W-1:0] MAXH = DST_DIM_W'(MAX_SRC_HEIGHT);

  // configuration
  logic [SRC_DIM_W-1:0] src_width, src_height;
  logic [DST_DIM_W-1:0] dst_width, dst_height;
  logic [STEP_W-1:0]    step_x, step_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_DIM_W'(1);
      src_height <= SRC_DIM_W'(1);
      dst_width  <= DST_DIM_W'(1);
      dst_height <= DST_DIM_W'(1);
      step_x     <= STEP_W'(ONE);
      step_y     <= STEP_W'(ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_width  <= cfg_data[DST_DIM_W-1:0];
        REG_DST_HEIGHT: dst_height <= cfg_data[DST_DIM_W-1:0];
        REG_STEP_X:     step_x     <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:     step_y     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input word fields
  logic              in_kind;
  logic [POS_W-1:0]  in_pos_x, in_pos_y;
  logic [PIX_W-1:0]  in_pix;

  assign in_kind  = s_axis_tuser[0];
  assign in_pos_x = s_axis_tdata[POS_W-1:0];
  assign in_pos_y = s_axis_tdata[2*POS_W-1:POS_W];
  assign in_pix   = s_axis_tdata[2*POS_W +: PIX_W];

  // pipeline control
  logic run;        // output side can take a new result
  logic s1_move, s2_done;

  // ---- stage 1: scale position, range check
  logic             s1_valid, s1_kind, s1_err;
  logic [PW-1:0]    s1_sx, s1_sy;
  logic [POS_W-1:0] s1_px, s1_py;
  logic [PIX_W-1:0] s1_pix;

  assign s_axis_tready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_kind <= in_kind;
      s1_err  <= (DST_DIM_W'(in_pos_x) >= dst_width) || (DST_DIM_W'(in_pos_y) >= dst_height);
      s1_sx   <= PW'(in_pos_x) * PW'(step_x);
      s1_sy   <= PW'(in_pos_y) * PW'(step_y);
      s1_px   <= in_pos_x;
      s1_py   <= in_pos_y;
      s1_pix  <= in_pix;
    end
  end

  // ---- stage 1 -> 2: clamp neighbors to the stored image
  logic [DST_DIM_W-1:0] w_ext, h_ext, w_cl, h_cl;
  logic [CW-1:0]        w_last, x0, x1;
  logic [RW-1:0]        h_last, y0, y1;
  logic [XW-1:0]        x0f, y0f;
  logic [FRAC_BITS-1:0] rx, ry;

  always_comb begin
    w_ext = DST_DIM_W'(src_width);
    h_ext = DST_DIM_W'(src_height);
    if (src_width == '0)   w_cl = DST_DIM_W'(1);
    else if (w_ext > MAXW) w_cl = MAXW;
    else                   w_cl = w_ext;
    if (src_height == '0)  h_cl = DST_DIM_W'(1);
    else if (h_ext > MAXH) h_cl = MAXH;
    else                   h_cl = h_ext;
    w_last = CW'(w_cl - DST_DIM_W'(1));
    h_last = RW'(h_cl - DST_DIM_W'(1));

    x0f = s1_sx[PW-1:FRAC_BITS];
    y0f = s1_sy[PW-1:FRAC_BITS];
    rx  = s1_sx[FRAC_BITS-1:0];
    ry  = s1_sy[FRAC_BITS-1:0];
    x0  = (x0f > XW'(w_last)) ? w_last : x0f[CW-1:0];
    y0  = (y0f > XW'(h_last)) ? h_last : y0f[RW-1:0];
    x1  = (x0 == w_last) ? w_last : x0 + CW'(1);
    y1  = (y0 == h_last) ? h_last : y0 + RW'(1);
  end

  // ---- stage 2: memory issue (one write per in-bounds load, or four reads per in-range query)
  logic                 s2_valid, s2_kind, s2_err, s2_load_ok;
  logic [AW-1:0]        s2_waddr;
  logic [PIX_W-1:0]     s2_pix;
  logic [CW-1:0]        s2_x0, s2_x1;
  logic [RW-1:0]        s2_y0, s2_y1;
  logic [WW-1:0]        s2_wx0, s2_wy0;
  logic [FRAC_BITS-1:0] s2_rx, s2_ry;
  logic [1:0]           ph;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        rd_addr, mem_addr;

  assign run     = !m_axis_tvalid || m_axis_tready;
  assign mem_we  = s2_valid && (s2_kind == KIND_LOAD) && s2_load_ok;
  assign mem_re  = run && s2_valid && (s2_kind == KIND_QUERY) && !s2_err;
  assign s2_done = s2_valid && ((s2_kind == KIND_LOAD) ||
                                (run && (s2_err || ph == PH_BR)));
  assign s1_move = s1_valid && (!s2_valid || s2_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_kind    <= s1_kind;
      s2_err     <= s1_err;
      s2_load_ok <= (DST_DIM_W'(s1_px) < MAXW) && (DST_DIM_W'(s1_py) < MAXH);
      s2_waddr   <= {s1_py[RW-1:0], s1_px[CW-1:0]};
      s2_pix     <= s1_pix;
      s2_x0      <= x0;
      s2_x1      <= x1;
      s2_y0      <= y0;
      s2_y1      <= y1;
      s2_rx      <= rx;
      s2_ry      <= ry;
      s2_wx0     <= ONE - WW'(rx);
      s2_wy0     <= ONE - WW'(ry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_TL;
    end else if (mem_re) begin
      ph <= ph + 2'd1;
    end
  end

  always_comb begin
    unique case (ph)
      PH_TL:   rd_addr = {s2_y0, s2_x0};
      PH_TR:   rd_addr = {s2_y0, s2_x1};
      PH_BL:   rd_addr = {s2_y1, s2_x0};
      PH_BR:   rd_addr = {s2_y1, s2_x1};
      default: rd_addr = {s2_y1, s2_x1};
    endcase
    mem_addr = mem_we ? s2_waddr : rd_addr;
  end

  // single-port pixel memory, registered read
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= s2_pix;
    end else if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // ---- tag stage: travels beside the memory read
  logic                 t_valid, t_err;
  logic [1:0]           t_ph;
  logic [WW-1:0]        t_wx0, t_wy0;
  logic [FRAC_BITS-1:0] t_rx, t_ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (run) begin
      t_valid <= s2_valid && (s2_kind == KIND_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      t_err <= s2_err;
      t_ph  <= ph;
      t_wx0 <= s2_wx0;
      t_wy0 <= s2_wy0;
      t_rx  <= s2_rx;
      t_ry  <= s2_ry;
    end
  end

  // ---- blend: horizontal pass per row, top row scaled by wy0 when done
  logic [HW-1:0]        h_acc [NUM_CH];
  logic [ACW-1:0]       v_top [NUM_CH];
  logic                 f_valid, f_err;
  logic [HW-1:0]        f_bot [NUM_CH];
  logic [ACW-1:0]       f_top [NUM_CH];
  logic [FRAC_BITS-1:0] f_ry;

  always_ff @(posedge clk) begin
    if (run && t_valid && !t_err) begin
      for (int c = 0; c < NUM_CH; c++) begin
        case (t_ph)
          PH_TL: h_acc[c] <= HW'(rdata[c*CH_W +: CH_W]) * HW'(t_wx0);
          PH_TR: h_acc[c] <= h_acc[c] + HW'(rdata[c*CH_W +: CH_W]) * HW'(t_rx);
          PH_BL: begin
            v_top[c] <= ACW'(h_acc[c]) * ACW'(t_wy0);
            h_acc[c] <= HW'(rdata[c*CH_W +: CH_W]) * HW'(t_wx0);
          end
          default: begin
            f_bot[c] <= h_acc[c] + HW'(rdata[c*CH_W +: CH_W]) * HW'(t_rx);
            f_top[c] <= v_top[c];
          end
        endcase
      end
      f_ry <= t_ry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (run) begin
      f_valid <= t_valid && (t_err || t_ph == PH_BR);
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      f_err <= t_err;
    end
  end

  // ---- output register
  logic [ACW-1:0] acc [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c] = f_top[c] + ACW'(f_bot[c]) * ACW'(f_ry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (run) begin
      m_axis_tvalid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run && f_valid) begin
      for (int c = 0; c < NUM_CH; c++) begin
        m_axis_tdata[c*CH_W +: CH_W] <= f_err ? '0 : acc[c][2*FRAC_BITS +: CH_W];
      end
      m_axis_tuser <= OUT_TUSER_W'(f_err);
    end
  end

endmodule

@@ design/brs_check.sv @@
// ----------------------------------------------------------------------------
// brs_check
// Port-level checks on the result stream of the resampler.
// ----------------------------------------------------------------------------
module brs_check
  import brs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // an out-of-range query carries zero channels
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("range error word with nonzero channels");

endmodule

bind bilinear_rgba_resampler brs_check u_brs_check (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bilinear RGBA resampler testbench
// Drives load and query words over the input stream with bursty timing, stalls
// the output stream on its own pattern, and checks every returned pixel
// against a bit-exact fixed-point blend computed from a shadow pixel store.
// In-range queries are only issued once all four neighbor pixels have been loaded.
// ----------------------------------------------------------------------------
import brs_pkg::*;

localparam int SRC_MAX     = 256;
localparam int FRAC        = 16;
localparam int STORE_WORDS = SRC_MAX * SRC_MAX;
localparam longint unsigned ONE = 64'd1 << FRAC;

// indexes past the register list; writes there must do nothing
localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

typedef struct {
  chan_t ch [NUM_CH];
  logic  range_err;
} blend_t;

class blend_checker;
  logic [PIX_W-1:0]     pixels [STORE_WORDS];
  logic [SRC_DIM_W-1:0] src_w, src_h;
  logic [DST_DIM_W-1:0] dst_w, dst_h;
  logic [STEP_W-1:0]    step_x, step_y;
  blend_t               due [$];
  string                chan_tag [NUM_CH] = '{"red", "green", "blue", "alpha"};
  int                   mismatches, loads, queries, flagged, results;

  function new();
    src_w  = 1;
    src_h  = 1;
    dst_w  = 1;
    dst_h  = 1;
    step_x = STEP_W'(ONE);
    step_y = STEP_W'(ONE);
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SRC_WIDTH:  src_w  = val[SRC_DIM_W-1:0];
      REG_SRC_HEIGHT: src_h  = val[SRC_DIM_W-1:0];
      REG_DST_WIDTH:  dst_w  = val[DST_DIM_W-1:0];
      REG_DST_HEIGHT: dst_h  = val[DST_DIM_W-1:0];
      REG_STEP_X:     step_x = val[STEP_W-1:0];
      REG_STEP_Y:     step_y = val[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // zero reads as one, oversize saturates
  function longint unsigned fit_dim(logic [SRC_DIM_W-1:0] v);
    if (v == 0) return 1;
    return (v > SRC_MAX) ? SRC_MAX : v;
  endfunction

  // store addresses of the four neighbors (TL, TR, BL, BR) and the fractions
  function void taps(input logic [POS_W-1:0] px, py, output int unsigned a [4],
                     output longint unsigned rx, ry);
    longint unsigned w, h, sx, sy, x0, y0, x1, y1;
    w  = fit_dim(src_w);
    h  = fit_dim(src_h);
    sx = longint'(px) * step_x;
    sy = longint'(py) * step_y;
    x0 = sx >> FRAC;
    y0 = sy >> FRAC;
    rx = sx & (ONE - 1);
    ry = sy & (ONE - 1);
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
    y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
    a[PH_TL] = y0 * SRC_MAX + x0;
    a[PH_TR] = y0 * SRC_MAX + x1;
    a[PH_BL] = y1 * SRC_MAX + x0;
    a[PH_BR] = y1 * SRC_MAX + x1;
  endfunction

  function blend_t blend_at(logic [POS_W-1:0] px, py);
    blend_t          e;
    int unsigned     a [4];
    longint unsigned rx, ry, acc;
    longint unsigned wt [4];
    logic [PIX_W-1:0] p [4];
    e.range_err = 1'b0;
    if (px >= dst_w || py >= dst_h) begin
      foreach (e.ch[c]) e.ch[c] = '0;
      e.range_err = 1'b1;
      return e;
    end
    taps(px, py, a, rx, ry);
    wt[PH_TL] = (ONE - rx) * (ONE - ry);
    wt[PH_TR] = rx * (ONE - ry);
    wt[PH_BL] = (ONE - rx) * ry;
    wt[PH_BR] = rx * ry;
    foreach (a[k]) p[k] = pixels[a[k]];
    for (int c = 0; c < NUM_CH; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += wt[k] * p[k][c*CH_W +: CH_W];
      e.ch[c] = chan_t'(acc >> (2 * FRAC));
    end
    return e;
  endfunction

  function void absorb_word(logic kind, logic [IN_TDATA_W-1:0] d);
    logic [POS_W-1:0] px, py;
    blend_t           e;
    px = d[POS_W-1:0];
    py = d[2*POS_W-1:POS_W];
    if (kind == KIND_LOAD) begin
      loads++;
      if (px < SRC_MAX && py < SRC_MAX) pixels[py * SRC_MAX + px] = d[IN_TDATA_W-1:2*POS_W];
    end else begin
      queries++;
      e = blend_at(px, py);
      if (e.range_err) flagged++;
      due.push_back(e);
    end
  endfunction

  task report(string what);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task check_pixel(logic [OUT_TDATA_W-1:0] d, logic err);
    blend_t e;
    if (due.size() == 0) begin
      report($sformatf("pixel %h flag %b with none outstanding", d, err));
      return;
    end
    e = due.pop_front();
    results++;
    for (int c = 0; c < NUM_CH; c++) begin
      if (d[c*CH_W +: CH_W] !== e.ch[c])
        report($sformatf("result %0d %s got %h want %h", results, chan_tag[c],
                         d[c*CH_W +: CH_W], e.ch[c]));
    end
    if (err !== e.range_err)
      report($sformatf("result %0d range_error got %b want %b", results, err, e.range_err));
  endtask
endclass

module tb_top;

  localparam int DRAIN_CYCLES = 24;
  localparam int ITEM_TARGET  = 1350;

  typedef enum int {RX_OPEN, RX_COIN, RX_STARVED, RX_PERIODIC} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // pos_x, pos_y, red, green, blue, alpha
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // red, green, blue, alpha
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // range_error
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  blend_checker sb = new();
  bit           planned [STORE_WORDS];
  int           burst_left = 0;
  int           n_items = 0;
  int           n_settings = 1;
  rx_mode_t     rx_mode = RX_OPEN;
  int           rx_left = 0;
  int unsigned  rx_tick = 0;

  bilinear_rgba_resampler #(
    .MAX_SRC_WIDTH(SRC_MAX),
    .MAX_SRC_HEIGHT(SRC_MAX),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.absorb_word(s_axis_tuser[0], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  // output backpressure: switch between a few stall styles every so often
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3, 0));
      rx_left = $urandom_range(300, 20);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= $urandom_range(1, 0);
      RX_STARVED:  m_axis_tready <= ($urandom_range(7, 0) == 0);
      default:     m_axis_tready <= (rx_tick % 3 != 0);
    endcase
  end

  task automatic send_word(input logic kind, input logic [POS_W-1:0] x, y,
                           input logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(12, 1);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {pix, y, x};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    n_items++;
  endtask

  task automatic send_load(input logic [POS_W-1:0] x, y, input logic [PIX_W-1:0] pix);
    if (x < SRC_MAX && y < SRC_MAX) planned[y * SRC_MAX + x] = 1'b1;
    send_word(KIND_LOAD, x, y, pix);
  endtask

  // fill in any neighbor not yet written, then ask for the pixel
  task automatic issue_query(input logic [POS_W-1:0] px, py);
    int unsigned     a [4];
    longint unsigned rx, ry;
    if (px < sb.dst_w && py < sb.dst_h) begin
      sb.taps(px, py, a, rx, ry);
      foreach (a[i]) begin
        if (!planned[a[i]]) send_load(POS_W'(a[i] % SRC_MAX), POS_W'(a[i] / SRC_MAX), $urandom());
      end
    end
    send_word(KIND_QUERY, px, py, $urandom());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every outstanding pixel is back and the pipe has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_pos(input logic [DST_DIM_W-1:0] dim);
    int unsigned top;
    top = (dim > 4096) ? 4096 : dim;
    case ($urandom_range(9, 0))
      0: return $urandom_range(4095, 0);
      1: return (top == 0) ? '0 : POS_W'(top - 1);
      2: return (top >= 4096) ? 12'hFFF : POS_W'(top);
      default: return (top == 0) ? POS_W'($urandom_range(4095, 0))
                                 : POS_W'($urandom_range(top - 1, 0));
    endcase
  endfunction

  function automatic logic [SRC_DIM_W-1:0] pick_src();
    case ($urandom_range(19, 0))
      0:       return 0;
      1:       return 511;
      2, 3:    return 256;
      4, 5, 6: return $urandom_range(255, 9);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  function automatic logic [DST_DIM_W-1:0] pick_dst();
    case ($urandom_range(19, 0))
      0:             return 0;
      1:             return 8191;
      2:             return 4096;
      3, 4, 5, 6:    return $urandom_range(8190, 1);
      default:       return $urandom_range(24, 1);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step(input logic [SRC_DIM_W-1:0] s,
                                                  input logic [DST_DIM_W-1:0] d);
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      2:       return STEP_W'(1) << 24;
      3, 4:    return STEP_W'($urandom());
      default: return (d == 0) ? STEP_W'(ONE) : STEP_W'((sb.fit_dim(s) << FRAC) / d);
    endcase
  endfunction

  task automatic new_setting(input bit fixed_max);
    logic [SRC_DIM_W-1:0] sw, sh;
    logic [DST_DIM_W-1:0] dw, dh;
    if (fixed_max) begin
      sw = 256;
      sh = 256;
      dw = 4096;
      dh = 256;
    end else begin
      sw = pick_src();
      sh = pick_src();
      dw = pick_dst();
      dh = pick_dst();
    end
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_STEP_X, fixed_max ? CFG_DATA_W'(1 << 12) : pick_step(sw, dw));
    write_reg(REG_STEP_Y, fixed_max ? CFG_DATA_W'(ONE) : pick_step(sh, dh));
    n_settings++;
  endtask

  task automatic run_phase(input int n);
    int pick;
    repeat (n) begin
      if (n_items >= ITEM_TARGET) break;
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
        issue_query(pick_pos(sb.dst_w), pick_pos(sb.dst_h));
      end else if (pick < 85) begin
        send_load(POS_W'($urandom_range(sb.fit_dim(sb.src_w) - 1, 0)),
                  POS_W'($urandom_range(sb.fit_dim(sb.src_h) - 1, 0)), $urandom());
      end else if (pick < 95) begin
        send_load($urandom_range(SRC_MAX - 1, 0), $urandom_range(SRC_MAX - 1, 0), $urandom());
      end else if (pick < 98) begin
        send_load($urandom_range(4095, SRC_MAX), $urandom_range(4095, 0), $urandom());
      end else begin
        send_load($urandom_range(4095, 0), $urandom_range(4095, SRC_MAX), $urandom());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset setting: 1x1 source, 1x1 output, unit steps
    send_load(0, 0, 32'hFFFF_FFFF);
    issue_query(0, 0);
    issue_query(1, 0);
    issue_query(12'hFFF, 12'hFFF);
    send_load(12'hFFF, 12'hFFF, $urandom());
    send_load(256, 0, 32'h0000_0000);
    send_load(0, 256, 32'h0000_0000);   // would land on (0,0) if the row wrapped
    issue_query(0, 0);
    settle();

    // 2x2 source upscaled by two: half weights and edge clamping
    write_reg(REG_SRC_WIDTH, 2);
    write_reg(REG_SRC_HEIGHT, 2);
    write_reg(REG_DST_WIDTH, 4);
    write_reg(REG_DST_HEIGHT, 4);
    write_reg(REG_STEP_X, 25'h0_8000);
    write_reg(REG_STEP_Y, 25'h0_8000);
    send_load(0, 0, 32'hFFFF_FFFF);
    send_load(1, 0, 32'h0000_0000);
    send_load(0, 1, 32'h00FF_00FF);
    send_load(1, 1, 32'h8040_2010);
    issue_query(1, 1);
    issue_query(3, 3);
    issue_query(2, 1);
    issue_query(4, 0);
    issue_query(0, 4);
    settle();

    // zero and oversized sizes, zero and full steps, writes past the list
    write_reg(REG_SRC_WIDTH, 0);
    write_reg(REG_SRC_HEIGHT, 511);
    write_reg(REG_DST_WIDTH, 0);
    write_reg(REG_DST_HEIGHT, 8191);
    write_reg(REG_STEP_X, 0);
    write_reg(REG_STEP_Y, 25'h1FF_FFFF);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    issue_query(0, 0);
    settle();
    write_reg(REG_DST_WIDTH, 8191);
    issue_query(12'hFFF, 12'hFFF);
    issue_query(12'hFFF, 0);
    issue_query(12'h800, 12'h001);
    settle();
    n_settings += 3;

    new_setting(1'b1);
    run_phase($urandom_range(120, 60));
    settle();
    while (n_items < ITEM_TARGET) begin
      new_setting(1'b0);
      run_phase($urandom_range(140, 60));
      settle();
    end

    $display("covered %0d loads and %0d queries (%0d flagged out of range) over %0d settings",
             sb.loads, sb.queries, sb.flagged, n_settings);
    $display("%0d pixels checked, %0d mismatches", sb.results, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d pixels outstanding", sb.due.size());
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
design/brs_pkg.sv
design/bilinear_rgba_resampler.sv
design/brs_check.sv
test/tb_top.sv
